### rtl/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg
// shared constants for the trapezoid line profile: default widths, register
// indexes and phase codes
// ----------------------------------------------------------------------------
package tlp_pkg;

	localparam int POS_BITS_DEF  = 24;
	localparam int TIME_BITS_DEF = 16;

	localparam int CFG_IDX_BITS = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_TICKS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_X    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_Y    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_START_Z    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELTA_X    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELTA_Y    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELTA_Z    = 3'd6;

	localparam logic [15:0] MOVE_TICKS_RST = 16'd1000;

	typedef logic [1:0] phase_t;

	localparam phase_t PH_ACCEL  = 2'd0;
	localparam phase_t PH_CRUISE = 2'd1;
	localparam phase_t PH_DECEL  = 2'd2;
	localparam phase_t PH_HOLD   = 2'd3;

endpackage

### rtl/trapezoid_line_profile_3axis.sv
// ----------------------------------------------------------------------------
// trapezoid_line_profile_3axis
// three-axis straight-line setpoint on a trapezoidal velocity profile
// ----------------------------------------------------------------------------
// Takes one tick value per item and returns x/y/z position and phase. One item
// is accepted every cycle while the output is not stalled. The rounding divider
// by 8*T^2 resolves one quotient bit per pipeline stage (four stages of phase
// decode, multiplies and the partial-product sum ahead of it, one stage of sign,
// add and saturation behind it). A stalled output freezes the whole pipeline.
// Configuration is written through cfg_valid / cfg_index / cfg_data and is always
// ready; the user must make writes go in while no item is in flight, as the block
// itself does not enforce it.
module trapezoid_line_profile_3axis #(
	parameter int POS_BITS  = tlp_pkg::POS_BITS_DEF,
	parameter int TIME_BITS = tlp_pkg::TIME_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tlp_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [((POS_BITS > TIME_BITS) ? POS_BITS : TIME_BITS)-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [TIME_BITS-1:0]               tick_time,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [POS_BITS-1:0]         pos_x,
	output logic signed [POS_BITS-1:0]         pos_y,
	output logic signed [POS_BITS-1:0]         pos_z,
	output logic [1:0]                         phase
);

	localparam int TW = TIME_BITS + 3;          // 5t, 10t-T, 4T
	localparam int FW = 2 * TW;                 // product factor
	localparam int PW = POS_BITS + TW;          // partial product
	localparam int RW = POS_BITS + FW + 1;      // dividend / remainder
	localparam int QW = POS_BITS;               // quotient bits
	localparam int SW = POS_BITS + 3;           // final sum width

	logic [TIME_BITS-1:0]       move_ticks_q;
	logic signed [POS_BITS-1:0] start_q [3];
	logic signed [POS_BITS-1:0] delta_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_ticks_q <= TIME_BITS'(tlp_pkg::MOVE_TICKS_RST);
			for (int k = 0; k < 3; k++) begin
				start_q[k] <= '0;
				delta_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				tlp_pkg::REG_MOVE_TICKS: move_ticks_q <= cfg_data[TIME_BITS-1:0];
				tlp_pkg::REG_START_X:    start_q[0] <= cfg_data[POS_BITS-1:0];
				tlp_pkg::REG_START_Y:    start_q[1] <= cfg_data[POS_BITS-1:0];
				tlp_pkg::REG_START_Z:    start_q[2] <= cfg_data[POS_BITS-1:0];
				tlp_pkg::REG_DELTA_X:    delta_q[0] <= cfg_data[POS_BITS-1:0];
				tlp_pkg::REG_DELTA_Y:    delta_q[1] <= cfg_data[POS_BITS-1:0];
				tlp_pkg::REG_DELTA_Z:    delta_q[2] <= cfg_data[POS_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic out_valid_q;
	logic en;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// stage 1: phase decode and the two multiplier operands
	logic [TW-1:0]   t_w, tt_w, t5_w, t4x_w, x_w, x5_w, a_w, b_w;
	tlp_pkg::phase_t ph_w;

	always_comb begin
		t_w   = TW'(tick_time);
		tt_w  = TW'(move_ticks_q);
		t5_w  = (t_w << 2) + t_w;
		t4x_w = tt_w << 2;
		if (tick_time >= move_ticks_q)
			ph_w = tlp_pkg::PH_HOLD;
		else if (t5_w <= tt_w)
			ph_w = tlp_pkg::PH_ACCEL;
		else if (t5_w <= t4x_w)
			ph_w = tlp_pkg::PH_CRUISE;
		else
			ph_w = tlp_pkg::PH_DECEL;
		x_w  = (ph_w == tlp_pkg::PH_ACCEL) ? t_w : (tt_w - t_w);
		x5_w = (x_w << 2) + x_w;
		case (ph_w)
			tlp_pkg::PH_CRUISE: begin
				a_w = (t5_w << 1) - tt_w;
				b_w = tt_w;
			end
			tlp_pkg::PH_HOLD: begin
				a_w = '0;
				b_w = '0;
			end
			default: begin
				a_w = x5_w;
				b_w = x5_w;
			end
		endcase
	end

	logic            v_s1;
	tlp_pkg::phase_t ph_s1;
	logic [TW-1:0]   a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= ph_w;
			a_s1  <= a_w;
			b_s1  <= b_w;
		end
	end

	// stage 2: factor 25x^2 or (10t-T)*T, and T^2
	logic                   v_s2;
	tlp_pkg::phase_t        ph_s2;
	logic [FW-1:0]          f_s2;
	logic [2*TIME_BITS-1:0] tsq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s2  <= ph_s1;
			f_s2   <= FW'(a_s1) * FW'(b_s1);
			tsq_s2 <= (2*TIME_BITS)'(move_ticks_q) * (2*TIME_BITS)'(move_ticks_q);
		end
	end

	// stage 3: |d| times the low and high halves of the factor
	logic [POS_BITS-1:0] ad_w [3];

	always_comb begin
		for (int k = 0; k < 3; k++)
			ad_w[k] = delta_q[k][POS_BITS-1] ? (POS_BITS'(0) - delta_q[k]) : delta_q[k];
	end

	logic                   v_s3;
	tlp_pkg::phase_t        ph_s3;
	logic [PW-1:0]          plo_s3 [3];
	logic [PW-1:0]          phi_s3 [3];
	logic [2*TIME_BITS-1:0] tsq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s3  <= ph_s2;
			tsq_s3 <= tsq_s2;
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= PW'(ad_w[k]) * PW'(f_s2[TW-1:0]);
				phi_s3[k] <= PW'(ad_w[k]) * PW'(f_s2[FW-1:TW]);
			end
		end
	end

	// stage 4 into divider slot 0: dividend |d|*F + 4T^2, divisor 8T^2
	logic            dv_v_s   [QW+1];
	tlp_pkg::phase_t dv_ph_s  [QW+1];
	logic [RW-1:0]   dv_den_s [QW+1];
	logic [RW-1:0]   dv_rem_s [QW+1][3];
	logic [QW-1:0]   dv_quo_s [QW+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else if (en)
			dv_v_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ph_s[0]  <= ph_s3;
			dv_den_s[0] <= RW'(tsq_s3) << 3;
			for (int k = 0; k < 3; k++) begin
				dv_rem_s[0][k] <= (RW'(phi_s3[k]) << TW) + RW'(plo_s3[k])
					+ (RW'(tsq_s3) << 2);
				dv_quo_s[0][k] <= '0;
			end
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [RW-1:0] sh_w;
		assign sh_w = dv_den_s[j] << (QW - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j+1] <= 1'b0;
			else if (en)
				dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ph_s[j+1]  <= dv_ph_s[j];
				dv_den_s[j+1] <= dv_den_s[j];
				for (int k = 0; k < 3; k++) begin
					if (dv_rem_s[j][k] >= sh_w) begin
						dv_rem_s[j+1][k] <= dv_rem_s[j][k] - sh_w;
						dv_quo_s[j+1][k] <= {dv_quo_s[j][k][QW-2:0], 1'b1};
					end else begin
						dv_rem_s[j+1][k] <= dv_rem_s[j][k];
						dv_quo_s[j+1][k] <= {dv_quo_s[j][k][QW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// last stage: sign, base point, saturation
	logic signed [SW-1:0]       off_w  [3];
	logic signed [SW-1:0]       base_w [3];
	logic signed [SW-1:0]       sum_w  [3];
	logic signed [POS_BITS-1:0] sat_w  [3];
	tlp_pkg::phase_t            ph_f;

	localparam logic signed [SW-1:0] PMAX = SW'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

	assign ph_f = dv_ph_s[QW];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			off_w[k] = SW'(signed'({1'b0, dv_quo_s[QW][k]}));
			if (delta_q[k][POS_BITS-1])
				off_w[k] = -off_w[k];
			base_w[k] = SW'(start_q[k]);
			if (ph_f == tlp_pkg::PH_DECEL || ph_f == tlp_pkg::PH_HOLD)
				base_w[k] = base_w[k] + SW'(delta_q[k]);
			case (ph_f)
				tlp_pkg::PH_DECEL: sum_w[k] = base_w[k] - off_w[k];
				tlp_pkg::PH_HOLD:  sum_w[k] = base_w[k];
				default:           sum_w[k] = base_w[k] + off_w[k];
			endcase
			if (sum_w[k] > PMAX)
				sat_w[k] = POS_BITS'(PMAX);
			else if (sum_w[k] < PMIN)
				sat_w[k] = POS_BITS'(PMIN);
			else
				sat_w[k] = sum_w[k][POS_BITS-1:0];
		end
	end

	logic signed [POS_BITS-1:0] pos_q [3];
	tlp_pkg::phase_t            phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= dv_v_s[QW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_q <= ph_f;
			for (int k = 0; k < 3; k++)
				pos_q[k] <= sat_w[k];
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_q[0];
	assign pos_y     = pos_q[1];
	assign pos_z     = pos_q[2];
	assign phase     = phase_q;

endmodule
